// ----- src/lr_pkg.sv -----
package lr_pkg;

    localparam int COORD_W   = 13;
    localparam int IN_W      = 16;
    localparam int DELTA_W   = COORD_W + 1;
    localparam int DEN_W     = COORD_W + 1;
    localparam int INC_W     = DELTA_W + 1;
    localparam int ERR_W     = DEN_W + 3;
    localparam int COLOR_W   = 32;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIM   = 4096;

    localparam int CMD_DEPTH   = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH   = 2;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR  = 2'd2;

    localparam logic [COORD_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [COORD_W-1:0] HEIGHT_RESET = 13'd480;
    localparam logic [COLOR_W-1:0] COLOR_RESET  = 32'hFF00_0000;

    typedef struct packed {
        logic [COORD_W-1:0] width;
        logic [COORD_W-1:0] height;
        logic [COLOR_W-1:0] color;
    } cfg_t;

    typedef struct packed {
        logic                     is_start;
        logic                     walk_on_x;
        logic [COORD_W-1:0]       pos;
        logic [COORD_W-1:0]       stop;
        logic [COORD_W-1:0]       other;
        logic [DEN_W-1:0]         den;
        logic signed [INC_W-1:0]  inc;
    } cmd_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               in_image;
        logic [COLOR_W-1:0] color;
        logic               last;
    } res_t;

endpackage

// ----- src/lr_front.sv -----
module lr_front (
    input  logic                                opcode,
    input  logic signed [lr_pkg::IN_W-1:0]      start_x,
    input  logic signed [lr_pkg::IN_W-1:0]      start_y,
    input  logic signed [lr_pkg::IN_W-1:0]      end_x,
    input  logic signed [lr_pkg::IN_W-1:0]      end_y,
    input  lr_pkg::cfg_t                        cfg,
    output lr_pkg::cmd_t                        cmd
);

    function automatic logic [lr_pkg::COORD_W-1:0] clamp_to(
        input logic signed [lr_pkg::IN_W-1:0] v,
        input logic [lr_pkg::COORD_W-1:0]     hi
    );
        logic signed [lr_pkg::IN_W-1:0] hi_ext;
        hi_ext = $signed({{(lr_pkg::IN_W - lr_pkg::COORD_W){1'b0}}, hi});
        if (v < 0)
        begin
            return '0;
        end
        else if (v > hi_ext)
        begin
            return hi;
        end
        else
        begin
            return v[lr_pkg::COORD_W-1:0];
        end
    endfunction

    logic [lr_pkg::COORD_W-1:0]        x1, y1, x2, y2;
    logic [lr_pkg::COORD_W-1:0]        ax, ay, bx, by;
    logic signed [lr_pkg::DELTA_W-1:0] sx, sy, abs_x, abs_y, minor_d;
    logic [lr_pkg::COORD_W-1:0]        major_lo, major_hi, major_d;
    logic                              on_x, swap;

    always_comb
    begin
        x1 = clamp_to(start_x, cfg.width);
        y1 = clamp_to(start_y, cfg.height);
        x2 = clamp_to(end_x, cfg.width);
        y2 = clamp_to(end_y, cfg.height);
        sx = $signed({1'b0, x2}) - $signed({1'b0, x1});
        sy = $signed({1'b0, y2}) - $signed({1'b0, y1});
        abs_x = sx[lr_pkg::DELTA_W-1] ? -sx : sx;
        abs_y = sy[lr_pkg::DELTA_W-1] ? -sy : sy;
        on_x = (x1 != x2) && (abs_x > abs_y);
        swap = on_x ? (x2 < x1) : (y2 < y1);
        ax = swap ? x2 : x1;
        ay = swap ? y2 : y1;
        bx = swap ? x1 : x2;
        by = swap ? y1 : y2;
        major_lo = on_x ? ax : ay;
        major_hi = on_x ? bx : by;
        major_d  = major_hi - major_lo;
        minor_d  = on_x ? ($signed({1'b0, by}) - $signed({1'b0, ay}))
                        : ($signed({1'b0, bx}) - $signed({1'b0, ax}));

        cmd.is_start  = (opcode == lr_pkg::OP_START);
        cmd.walk_on_x = on_x;
        cmd.pos       = major_lo;
        cmd.stop      = major_hi;
        cmd.other     = on_x ? ay : ax;
        cmd.den       = {major_d, 1'b0};
        cmd.inc       = {minor_d, 1'b0};
    end

endmodule

// ----- src/lr_cmd_queue.sv -----
module lr_cmd_queue (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         wr_en,
    input  lr_pkg::cmd_t wr_cmd,
    input  logic         rd_en,
    output lr_pkg::cmd_t rd_cmd,
    output logic         full,
    output logic         empty
);

    lr_pkg::cmd_t                     mem [lr_pkg::CMD_DEPTH];
    logic [lr_pkg::CMD_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [lr_pkg::CMD_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [lr_pkg::CMD_CNT_W-1:0]     count_reg, count_next;
    logic                             do_wr, do_rd;

    assign full   = (count_reg == lr_pkg::CMD_CNT_W'(lr_pkg::CMD_DEPTH));
    assign empty  = (count_reg == '0);
    assign rd_cmd = mem[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == lr_pkg::CMD_PTR_W'(lr_pkg::CMD_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == lr_pkg::CMD_PTR_W'(lr_pkg::CMD_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ----- src/lr_back.sv -----
module lr_back (
    input  logic         clk,
    input  logic         rst_n,
    input  lr_pkg::cmd_t cmd,
    input  logic         cmd_empty,
    output logic         cmd_pop,
    input  lr_pkg::cfg_t cfg,
    input  logic         pop,
    output logic         empty,
    output lr_pkg::res_t res
);

    logic                              busy_reg, busy_next;
    logic                              walk_on_x_reg, walk_on_x_next;
    logic [lr_pkg::COORD_W-1:0]        pos_reg, pos_next;
    logic [lr_pkg::COORD_W-1:0]        stop_reg, stop_next;
    logic [lr_pkg::COORD_W-1:0]        other_reg, other_next;
    logic [lr_pkg::DEN_W-1:0]          den_reg, den_next;
    logic [lr_pkg::DEN_W-1:0]          rem_reg, rem_next;
    logic signed [lr_pkg::INC_W-1:0]   inc_reg, inc_next;

    lr_pkg::res_t                      out_mem [lr_pkg::OUT_DEPTH];
    logic [lr_pkg::OUT_PTR_W-1:0]      out_wr_reg, out_wr_next;
    logic [lr_pkg::OUT_PTR_W-1:0]      out_rd_reg, out_rd_next;
    logic [lr_pkg::OUT_CNT_W-1:0]      out_count_reg, out_count_next;

    logic                              emits, advance, out_pop, fin;
    logic signed [lr_pkg::ERR_W-1:0]   err_sum, den_ext;
    lr_pkg::res_t                      res_new;

    assign emits   = !cmd.is_start && busy_reg;
    assign advance = !cmd_empty
                     && (!emits || (out_count_reg != lr_pkg::OUT_CNT_W'(lr_pkg::OUT_DEPTH)));
    assign cmd_pop = advance;
    assign out_pop = pop && (out_count_reg != '0);
    assign empty   = (out_count_reg == '0);
    assign res     = out_mem[out_rd_reg];
    assign fin     = (pos_reg >= stop_reg);

    always_comb
    begin
        res_new.x        = walk_on_x_reg ? pos_reg : other_reg;
        res_new.y        = walk_on_x_reg ? other_reg : pos_reg;
        res_new.in_image = (res_new.x < cfg.width) && (res_new.y < cfg.height);
        res_new.color    = cfg.color;
        res_new.last     = fin;
    end

    always_comb
    begin
        den_ext = $signed({{(lr_pkg::ERR_W - lr_pkg::DEN_W){1'b0}}, den_reg});
        err_sum = $signed({{(lr_pkg::ERR_W - lr_pkg::DEN_W){1'b0}}, rem_reg})
                  + {{(lr_pkg::ERR_W - lr_pkg::INC_W){inc_reg[lr_pkg::INC_W-1]}}, inc_reg};

        busy_next      = busy_reg;
        walk_on_x_next = walk_on_x_reg;
        pos_next       = pos_reg;
        stop_next      = stop_reg;
        other_next     = other_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        inc_next       = inc_reg;

        if (advance)
        begin
            if (cmd.is_start)
            begin
                busy_next      = 1'b1;
                walk_on_x_next = cmd.walk_on_x;
                pos_next       = cmd.pos;
                stop_next      = cmd.stop;
                other_next     = cmd.other;
                den_next       = cmd.den;
                rem_next       = {1'b0, cmd.den[lr_pkg::DEN_W-1:1]};
                inc_next       = cmd.inc;
            end
            else if (busy_reg)
            begin
                if (fin)
                begin
                    busy_next = 1'b0;
                end
                else
                begin
                    pos_next = pos_reg + 1'b1;
                    if (den_reg != '0)
                    begin
                        if (err_sum >= den_ext)
                        begin
                            rem_next   = lr_pkg::DEN_W'(err_sum - den_ext);
                            other_next = other_reg + 1'b1;
                        end
                        else if (err_sum < 0)
                        begin
                            rem_next   = lr_pkg::DEN_W'(err_sum + den_ext);
                            other_next = other_reg - 1'b1;
                        end
                        else
                        begin
                            rem_next = lr_pkg::DEN_W'(err_sum);
                        end
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_wr_next    = out_wr_reg;
        out_rd_next    = out_rd_reg;
        out_count_next = out_count_reg;
        if (advance && emits)
        begin
            out_wr_next = (out_wr_reg == lr_pkg::OUT_PTR_W'(lr_pkg::OUT_DEPTH - 1))
                          ? '0 : out_wr_reg + 1'b1;
        end
        if (out_pop)
        begin
            out_rd_next = (out_rd_reg == lr_pkg::OUT_PTR_W'(lr_pkg::OUT_DEPTH - 1))
                          ? '0 : out_rd_reg + 1'b1;
        end
        if ((advance && emits) && !out_pop)
        begin
            out_count_next = out_count_reg + 1'b1;
        end
        else if (out_pop && !(advance && emits))
        begin
            out_count_next = out_count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_wr_reg    <= '0;
            out_rd_reg    <= '0;
            out_count_reg <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_wr_reg    <= out_wr_next;
            out_rd_reg    <= out_rd_next;
            out_count_reg <= out_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_on_x_reg <= walk_on_x_next;
        pos_reg       <= pos_next;
        stop_reg      <= stop_next;
        other_reg     <= other_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        inc_reg       <= inc_next;
        if (advance && emits)
        begin
            out_mem[out_wr_reg] <= res_new;
        end
    end

endmodule

// ----- src/line_rasterizer.sv -----
// Channel   Direction  Handshake            Payload
// input     in         push / full          opcode, start_x, start_y, end_x, end_y
// result    out        empty / pop          pixel_x, pixel_y, inside_res, color, last
// config    in         cfg_write            cfg_index, cfg_data
//
// Every item is classified as it is accepted and is registered in the command queue
// before the back end sees it. The back end retires one queued item per clock
// while the result buffer has room, so one pixel per clock is sustained while pop
// keeps up. Reset clears the command queue, the result buffer and the busy flag.
// When the two-entry result buffer fills, the back end stalls and the
// two-entry command queue raises full once it holds two items.
module line_rasterizer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                opcode,
    input  logic signed [lr_pkg::IN_W-1:0]      start_x,
    input  logic signed [lr_pkg::IN_W-1:0]      start_y,
    input  logic signed [lr_pkg::IN_W-1:0]      end_x,
    input  logic signed [lr_pkg::IN_W-1:0]      end_y,
    output logic                                empty,
    input  logic                                pop,
    output logic [lr_pkg::COORD_W-1:0]          pixel_x,
    output logic [lr_pkg::COORD_W-1:0]          pixel_y,
    output logic                                inside_res,
    output logic [lr_pkg::COLOR_W-1:0]          color,
    output logic                                last,
    input  logic                                cfg_write,
    input  logic [lr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lr_pkg::COLOR_W-1:0]          cfg_data
);

    logic [lr_pkg::COORD_W-1:0] width_reg, width_next;
    logic [lr_pkg::COORD_W-1:0] height_reg, height_next;
    logic [lr_pkg::COLOR_W-1:0] color_reg, color_next;
    lr_pkg::cfg_t               cfg;
    lr_pkg::cmd_t               front_cmd, head_cmd;
    lr_pkg::res_t               res;
    logic                       cmd_empty, cmd_pop;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        color_next  = color_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                lr_pkg::CFG_WIDTH:  width_next  = cfg_data[lr_pkg::COORD_W-1:0];
                lr_pkg::CFG_HEIGHT: height_next = cfg_data[lr_pkg::COORD_W-1:0];
                lr_pkg::CFG_COLOR:  color_next  = cfg_data;
                default:            color_next  = color_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= lr_pkg::WIDTH_RESET;
            height_reg <= lr_pkg::HEIGHT_RESET;
            color_reg  <= lr_pkg::COLOR_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            color_reg  <= color_next;
        end
    end

    always_comb
    begin
        cfg.width  = (32'(width_reg) > lr_pkg::MAX_DIM)
                     ? lr_pkg::COORD_W'(lr_pkg::MAX_DIM) : width_reg;
        cfg.height = (32'(height_reg) > lr_pkg::MAX_DIM)
                     ? lr_pkg::COORD_W'(lr_pkg::MAX_DIM) : height_reg;
        cfg.color  = color_reg;
    end

    lr_front u_front (
        .opcode  (opcode),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .cfg     (cfg),
        .cmd     (front_cmd)
    );

    lr_cmd_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_cmd (front_cmd),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .full   (full),
        .empty  (cmd_empty)
    );

    lr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cfg       (cfg),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign pixel_x    = res.x;
    assign pixel_y    = res.y;
    assign inside_res = res.in_image;
    assign color      = res.color;
    assign last       = res.last;

endmodule

// ----- verif/tb_line_rasterizer.sv -----
module tb_line_rasterizer;

    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [lr_pkg::IN_W-1:0] coord_in_t;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int MAX_IDLE     = 18;
    localparam int RANDOM_ITEMS = 1080;

    logic                         clk;
    logic                         rst_n;
    logic                         push;
    logic                         full;
    logic                         opcode;
    coord_in_t                    start_x;
    coord_in_t                    start_y;
    coord_in_t                    end_x;
    coord_in_t                    end_y;
    logic                         empty;
    logic                         pop;
    logic [lr_pkg::COORD_W-1:0]   pixel_x;
    logic [lr_pkg::COORD_W-1:0]   pixel_y;
    logic                         inside_res;
    logic [lr_pkg::COLOR_W-1:0]   color;
    logic                         last;
    logic                         cfg_write;
    logic [lr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [lr_pkg::COLOR_W-1:0]   cfg_data;

    line_rasterizer u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .opcode     (opcode),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .inside_res (inside_res),
        .color      (color),
        .last       (last),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Image settings and line walk as the block should hold them.
    logic [lr_pkg::COORD_W-1:0] img_width;
    logic [lr_pkg::COORD_W-1:0] img_height;
    logic [lr_pkg::COLOR_W-1:0] img_color;
    logic                       line_active;
    logic                       walk_x;
    int                         walk_pos;
    int                         walk_end;
    int                         anch_x;
    int                         anch_y;
    int                         dx;
    int                         dy;

    lr_pkg::res_t               pending_pixels[$];
    lr_pkg::res_t               oldest_pixel;
    int                         error_count;
    int                         cycle_count;
    int                         item_count;
    int                         gap_max;
    int                         stall_max;
    int                         hold_cycles;

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic int dim_limit(logic [lr_pkg::COORD_W-1:0] r);
        return (int'(r) > lr_pkg::MAX_DIM) ? lr_pkg::MAX_DIM : int'(r);
    endfunction

    function automatic int clamp_coord(int v, int hi);
        if (v < 0)
            return 0;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    // Returns 1 unless the item is a step with no line in progress.
    function automatic bit rasterize_item(logic op, coord_in_t sx, coord_in_t sy,
                                          coord_in_t ex, coord_in_t ey);
        int           w;
        int           h;
        int           x1;
        int           y1;
        int           x2;
        int           y2;
        int           t;
        bit           swap;
        bit           fin;
        longint       px;
        longint       py;
        longint       off;
        lr_pkg::res_t pix;
        w = dim_limit(img_width);
        h = dim_limit(img_height);
        if (op == lr_pkg::OP_START)
        begin
            x1 = clamp_coord(int'(sx), w);
            y1 = clamp_coord(int'(sy), h);
            x2 = clamp_coord(int'(ex), w);
            y2 = clamp_coord(int'(ey), h);
            if (x1 != x2 && ((x2 > x1) ? x2 - x1 : x1 - x2) > ((y2 > y1) ? y2 - y1 : y1 - y2))
            begin
                walk_x = 1'b1;
                swap = x2 < x1;
            end
            else
            begin
                walk_x = 1'b0;
                swap = y2 < y1;
            end
            if (swap)
            begin
                t = x1; x1 = x2; x2 = t;
                t = y1; y1 = y2; y2 = t;
            end
            anch_x = x1;
            anch_y = y1;
            dx = x2 - x1;
            dy = y2 - y1;
            walk_pos = walk_x ? x1 : y1;
            walk_end = walk_x ? x2 : y2;
            line_active = 1'b1;
            return 1'b1;
        end
        if (!line_active)
            return 1'b0;
        if (walk_x)
        begin
            px = walk_pos;
            off = walk_pos - anch_x;
            py = anch_y;
            if (dx > 0)
                py = py + floor_div(2 * longint'(dy) * off + dx, 2 * longint'(dx));
        end
        else
        begin
            py = walk_pos;
            off = walk_pos - anch_y;
            px = anch_x;
            if (dy > 0)
                px = px + floor_div(2 * longint'(dx) * off + dy, 2 * longint'(dy));
        end
        fin = walk_pos >= walk_end;
        if (fin)
            line_active = 1'b0;
        else
            walk_pos = walk_pos + 1;
        pix.x = lr_pkg::COORD_W'(px);
        pix.y = lr_pkg::COORD_W'(py);
        pix.in_image = (px >= 0 && py >= 0 && px < w && py < h);
        pix.color = img_color;
        pix.last = fin;
        pending_pixels = {pending_pixels, pix};
        return 1'b1;
    endfunction

    task automatic send_item(logic op, coord_in_t sx, coord_in_t sy,
                             coord_in_t ex, coord_in_t ey);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        opcode <= op;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        do @(posedge clk); while (full);
        if (rasterize_item(op, sx, sy, ex, ey))
            item_count++;
    endtask

    task automatic send_step();
        send_item(lr_pkg::OP_STEP, coord_in_t'($urandom), coord_in_t'($urandom),
                  coord_in_t'($urandom), coord_in_t'($urandom));
    endtask

    task automatic wait_for_idle();
        int drain;
        push <= 1'b0;
        drain = 0;
        while (pending_pixels.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        if (pending_pixels.size() != 0)
        begin
            $display("%0t: %0d expected pixels never arrived", $time, pending_pixels.size());
            error_count++;
            pending_pixels.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic load_image_setup(int w, int h, logic [lr_pkg::COLOR_W-1:0] c);
        wait_for_idle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= lr_pkg::CFG_WIDTH;
        cfg_data <= lr_pkg::COLOR_W'(w);
        @(posedge clk);
        cfg_index <= lr_pkg::CFG_HEIGHT;
        cfg_data <= lr_pkg::COLOR_W'(h);
        @(posedge clk);
        cfg_index <= lr_pkg::CFG_COLOR;
        cfg_data <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
        img_width = lr_pkg::COORD_W'(w);
        img_height = lr_pkg::COORD_W'(h);
        img_color = c;
    endtask

    function automatic coord_in_t near_value(int center, int spread);
        return coord_in_t'(center + int'($urandom_range(0, 2 * spread)) - spread);
    endfunction

    task automatic random_line();
        int        w;
        int        h;
        int        kind;
        int        d;
        int        steps;
        int        remaining;
        coord_in_t x1;
        coord_in_t y1;
        coord_in_t x2;
        coord_in_t y2;
        w = dim_limit(img_width);
        h = dim_limit(img_height);
        kind = $urandom_range(0, 99);
        if (kind < 8)
        begin
            x1 = coord_in_t'($urandom);
            y1 = coord_in_t'($urandom);
            x2 = coord_in_t'($urandom);
            y2 = coord_in_t'($urandom);
        end
        else if (kind < 18)
        begin
            x1 = near_value($urandom_range(0, 1) ? w : 0, 3);
            y1 = near_value($urandom_range(0, 1) ? h : 0, 3);
            x2 = near_value($urandom_range(0, 1) ? w : 0, 3);
            y2 = near_value($urandom_range(0, 1) ? h : 0, 3);
        end
        else
        begin
            x1 = near_value($urandom_range(0, w), 6);
            y1 = near_value($urandom_range(0, h), 6);
            x2 = near_value(int'(x1), 12);
            y2 = near_value(int'(y1), 12);
            if (kind < 28)
            begin
                x2 = x1;
            end
            else if (kind < 36)
            begin
                d = $urandom_range(0, 10);
                x2 = coord_in_t'($urandom_range(0, 1) ? int'(x1) + d : int'(x1) - d);
                y2 = coord_in_t'($urandom_range(0, 1) ? int'(y1) + d : int'(y1) - d);
            end
        end
        send_item(lr_pkg::OP_START, x1, y1, x2, y2);
        remaining = line_active ? walk_end - walk_pos + 1 : 0;
        kind = $urandom_range(0, 99);
        if (remaining > 40)
            steps = $urandom_range(1, 40);
        else if (kind < 12)
            steps = $urandom_range(0, remaining);
        else if (kind < 22)
            steps = remaining + $urandom_range(1, 3);
        else
            steps = remaining;
        repeat (steps) send_step();
    endtask

    task automatic test_directed();
        send_step();
        send_item(lr_pkg::OP_START, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
        send_step();
        send_item(lr_pkg::OP_START, 16'sd10, 16'sd3, 16'sd10, 16'sd5);
        repeat (3) send_step();
        send_item(lr_pkg::OP_START, 16'sd0, 16'sd0, 16'sd3, 16'sd3);
        repeat (4) send_step();
        send_item(lr_pkg::OP_START, 16'sd2, 16'sd1, 16'sd0, 16'sd0);
        repeat (3) send_step();
        send_item(lr_pkg::OP_START, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);
        repeat (2) send_step();
        send_item(lr_pkg::OP_START, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_step();
        send_step();
    endtask

    task automatic test_register_extremes();
        load_image_setup(0, 0, 32'h0000_0000);
        repeat (6) random_line();
        load_image_setup(1, 1, 32'hFFFF_FFFF);
        repeat (6) random_line();
        load_image_setup(8191, lr_pkg::MAX_DIM, $urandom);
        repeat (6) random_line();
        load_image_setup(lr_pkg::MAX_DIM, 1, $urandom);
        repeat (6) random_line();
    endtask

    task automatic test_register_change_mid_line();
        load_image_setup(640, 480, 32'h1234_5678);
        send_item(lr_pkg::OP_START, 16'sd630, 16'sd10, 16'sd650, 16'sd12);
        repeat (4) send_step();
        load_image_setup(635, 480, 32'h89AB_CDEF);
        repeat (7) send_step();
        send_step();
    endtask

    task automatic test_input_stall();
        load_image_setup(640, 480, $urandom);
        gap_max = 0;
        hold_cycles = 300;
        send_item(lr_pkg::OP_START, 16'sd0, 16'sd0, 16'sd300, 16'sd20);
        repeat (80) send_step();
        while (hold_cycles != 0)
            @(posedge clk);
        gap_max = MAX_IDLE;
    endtask

    task automatic test_random();
        int phase;
        int target;
        int next_mode;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: load_image_setup(640, 480, $urandom);
                1: load_image_setup(lr_pkg::MAX_DIM, lr_pkg::MAX_DIM, $urandom);
                2: load_image_setup(17, 9, $urandom);
                3: load_image_setup($urandom_range(1, lr_pkg::MAX_DIM),
                                    $urandom_range(1, lr_pkg::MAX_DIM), $urandom);
                4: load_image_setup(6000, 3, $urandom);
                default: load_image_setup($urandom_range(1, 64), $urandom_range(1, 64),
                                          $urandom);
            endcase
            item_count = 0;
            next_mode = 0;
            target = RANDOM_ITEMS / 6;
            while (item_count < target)
            begin
                if (item_count >= next_mode)
                begin
                    case ($urandom_range(0, 3))
                        0:
                        begin
                            gap_max = 0;
                            stall_max = 0;
                        end
                        1:
                        begin
                            gap_max = MAX_IDLE;
                            stall_max = 0;
                        end
                        2:
                        begin
                            gap_max = 0;
                            stall_max = MAX_IDLE;
                        end
                        default:
                        begin
                            gap_max = MAX_IDLE;
                            stall_max = MAX_IDLE;
                        end
                    endcase
                    next_mode = item_count + 50;
                end
                if ($urandom_range(0, 99) < 5)
                    send_item(logic'($urandom_range(0, 1)), coord_in_t'($urandom),
                              coord_in_t'($urandom), coord_in_t'($urandom),
                              coord_in_t'($urandom));
                else
                    random_line();
            end
        end
        gap_max = MAX_IDLE;
        stall_max = MAX_IDLE;
    endtask

    task automatic compare_field(string name, logic [lr_pkg::COLOR_W-1:0] want,
                                 logic [lr_pkg::COLOR_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected pixel, expected none, got x=%0d y=%0d",
                         $time, pixel_x, pixel_y);
                error_count++;
            end
            else
            begin
                oldest_pixel = pending_pixels.pop_front();
                compare_field("pixel_x", lr_pkg::COLOR_W'(oldest_pixel.x),
                              lr_pkg::COLOR_W'(pixel_x));
                compare_field("pixel_y", lr_pkg::COLOR_W'(oldest_pixel.y),
                              lr_pkg::COLOR_W'(pixel_y));
                compare_field("inside_res", lr_pkg::COLOR_W'(oldest_pixel.in_image),
                              lr_pkg::COLOR_W'(inside_res));
                compare_field("color", oldest_pixel.color, color);
                compare_field("last", lr_pkg::COLOR_W'(oldest_pixel.last),
                              lr_pkg::COLOR_W'(last));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : result_receiver
        int stall;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        item_count = 0;
        gap_max = MAX_IDLE;
        stall_max = MAX_IDLE;
        hold_cycles = 0;
        img_width = lr_pkg::WIDTH_RESET;
        img_height = lr_pkg::HEIGHT_RESET;
        img_color = lr_pkg::COLOR_RESET;
        line_active = 1'b0;
        walk_x = 1'b0;
        walk_pos = 0;
        walk_end = 0;
        anch_x = 0;
        anch_y = 0;
        dx = 0;
        dy = 0;
        rst_n <= 1'b0;
        push <= 1'b0;
        opcode <= lr_pkg::OP_START;
        start_x <= '0;
        start_y <= '0;
        end_x <= '0;
        end_y <= '0;
        cfg_write <= 1'b0;
        cfg_index <= lr_pkg::CFG_WIDTH;
        cfg_data <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        test_register_change_mid_line();
        test_input_stall();
        test_random();

        wait_for_idle();
        repeat (6) @(posedge clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
